>>> rtl/imu_tcm_pkg.sv
// Package for the tilt-compensated cursor motion block.
// Holds shared types, constants and the step functions of the square root and divider.
// No dependencies.
package imu_tcm_pkg;

  localparam int unsigned SQRT_STEPS = 24;
  localparam int unsigned DIV_STEPS  = 24;

  // 16.384 LSB per dps times 1e6 us per s, in Q8 cursor units.
  localparam logic [23:0] SCALE_DIV = 24'd16384000;

  localparam logic [23:0] POS_MAX_Q = 24'h7FFFFF;
  localparam logic [23:0] NEG_MIN_Q = 24'h800000;

  typedef enum logic [0:0] {
    CFG_GYRO_DEADBAND = 1'b0,
    CFG_SPEED_GAIN    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [47:0] x;
    logic [25:0] rem;
    logic [23:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [23:0] nlo;
    logic [47:0] rem;
    logic [23:0] q;
  } div_st_t;

  // Values that ride along the square root stages.
  typedef struct packed {
    logic signed [15:0] gy;
    logic signed [31:0] aygz;
    logic signed [33:0] gsum;
    logic [31:0]        m;
    logic               az_neg;
  } sq_side_t;

  // Values that ride along the divider stages.
  typedef struct packed {
    logic [47:0] den;
    logic        neg_x;
    logic        neg_y;
    logic        big_x;
    logic        big_y;
  } dv_side_t;

  // One root bit per step: bring down two radicand bits and try (4*root + 1).
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
    sqrt_st_t    o;
    logic [25:0] r2;
    logic [25:0] trial;
    r2    = {s.rem[23:0], s.x[47:46]};
    trial = {s.root, 2'b01};
    o.x   = {s.x[45:0], 2'b00};
    if (r2 >= trial) begin
      o.rem  = r2 - trial;
      o.root = {s.root[22:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[22:0], 1'b0};
    end
    return o;
  endfunction

  // One quotient bit per step of a restoring division.
  function automatic div_st_t div_step(div_st_t s, logic [47:0] den);
    div_st_t     o;
    logic [48:0] r2;
    r2    = {s.rem, s.nlo[23]};
    o.nlo = {s.nlo[22:0], 1'b0};
    if (r2 >= {1'b0, den}) begin
      o.rem = 48'(r2 - {1'b0, den});
      o.q   = {s.q[22:0], 1'b1};
    end else begin
      o.rem = r2[47:0];
      o.q   = {s.q[22:0], 1'b0};
    end
    return o;
  endfunction

endpackage

>>> rtl/imu_tcm_if.sv
// Valid/ready channel interfaces for the sample input and the move output.
// No dependencies.
interface imu_tcm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic        [15:0] dt_us;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  dt_us, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                dt_us, output ready);
endinterface

interface imu_tcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] move_x;
  logic signed [23:0] move_y;
  logic               saturated;

  modport source (output valid, move_x, move_y, saturated, input ready);
  modport sink (input valid, move_x, move_y, saturated, output ready);
endinterface

>>> rtl/imu_tilt_compensated_cursor_motion.sv
// Top level of the tilt-compensated cursor motion pipeline.
// Depends on imu_tcm_pkg and the channel interfaces in imu_tcm_if.sv.
//
// Usage: one raw 6-axis sample plus its interval enters per beat on in_beat;
// one cursor move (move_x, move_y in signed Q15.8, plus a saturated flag)
// leaves per beat on out_beat. The gyro deadband and speed gain are written
// through cfg_we / cfg_index / cfg_wdata; the user must write them only while
// the pipeline is empty, as the block itself does not enforce this.
//
// Throughput is one sample per cycle while the output is not stalled. The
// depth comes from a 24-stage bit-per-stage square root (run twice side by
// side, for |a| and the x-z length) and a 24-stage restoring divider (one
// per axis), with a few multiply and add stages around them.
//
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults (deadband 16, gain 16.0). When the receiver holds ready
// low with a result waiting, the whole pipeline holds in place; nothing is
// dropped or repeated, and in_beat.ready falls until the output moves again.
module imu_tilt_compensated_cursor_motion (
  input  logic                  clk,
  input  logic                  rst_n,
  imu_tcm_in_if.sink            in_beat,
  imu_tcm_out_if.source         out_beat,
  input  logic                  cfg_we,
  input  imu_tcm_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]           cfg_wdata
);
  import imu_tcm_pkg::*;

  logic [14:0] gyro_deadband_r;
  logic [15:0] speed_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_deadband_r <= 15'd16;
      speed_gain_r    <= 16'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GYRO_DEADBAND: gyro_deadband_r <= cfg_wdata[14:0];
        CFG_SPEED_GAIN:    speed_gain_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; the output register decouples it.
  logic adv;
  logic out_valid_r;
  assign adv           = !out_valid_r || out_beat.ready;
  assign in_beat.ready = adv;

  // Deadband: magnitude of the raw rate against the threshold.
  function automatic logic signed [15:0] apply_db(logic signed [15:0] g, logic [14:0] db);
    logic [15:0] mag;
    mag = g[15] ? 16'(-g) : g;
    return (mag < {1'b0, db}) ? 16'sd0 : g;
  endfunction

  // Stage A: deadband and time-gain product.
  logic               a_v_r;
  logic signed [15:0] a_ax_r, a_ay_r, a_az_r, a_gx_r, a_gy_r, a_gz_r;
  logic [31:0]        a_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (adv) a_v_r <= in_beat.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ax_r <= in_beat.accel_x;
      a_ay_r <= in_beat.accel_y;
      a_az_r <= in_beat.accel_z;
      a_gx_r <= apply_db(in_beat.gyro_x, gyro_deadband_r);
      a_gy_r <= apply_db(in_beat.gyro_y, gyro_deadband_r);
      a_gz_r <= apply_db(in_beat.gyro_z, gyro_deadband_r);
      a_m_r  <= in_beat.dt_us * speed_gain_r;
    end
  end

  // Stage B: the 16x16 accel squares and accel-gyro products.
  logic               b_v_r;
  logic signed [31:0] b_xx_r, b_yy_r, b_zz_r, b_xg_r, b_yg_r, b_zg_r, b_aygz_r;
  logic signed [15:0] b_gy_r;
  logic [31:0]        b_m_r;
  logic               b_azn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (adv) b_v_r <= a_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_xx_r   <= a_ax_r * a_ax_r;
      b_yy_r   <= a_ay_r * a_ay_r;
      b_zz_r   <= a_az_r * a_az_r;
      b_xg_r   <= a_ax_r * a_gx_r;
      b_yg_r   <= a_ay_r * a_gy_r;
      b_zg_r   <= a_az_r * a_gz_r;
      b_aygz_r <= a_ay_r * a_gz_r;
      b_gy_r   <= a_gy_r;
      b_m_r    <= a_m_r;
      b_azn_r  <= a_az_r[15];
    end
  end

  // Stage C: sums of squares and the yaw dot product.
  logic        c_v_r;
  logic [31:0] c_s_r, c_sxz_r;
  sq_side_t    c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (adv) c_v_r <= b_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_sxz_r       <= {1'b0, b_xx_r[30:0]} + {1'b0, b_zz_r[30:0]};
      c_s_r         <= {1'b0, b_xx_r[30:0]} + {1'b0, b_zz_r[30:0]} + {1'b0, b_yy_r[30:0]};
      c_side_r.gy   <= b_gy_r;
      c_side_r.aygz <= b_aygz_r;
      c_side_r.gsum <= 34'(b_xg_r) + 34'(b_yg_r) + 34'(b_zg_r);
      c_side_r.m    <= b_m_r;
      c_side_r.az_neg <= b_azn_r;
    end
  end

  // Square root stages, one root bit each, for n and d side by side.
  logic     sq_v_r   [SQRT_STEPS];
  sqrt_st_t sq_n_r   [SQRT_STEPS];
  sqrt_st_t sq_d_r   [SQRT_STEPS];
  sq_side_t sq_side_r[SQRT_STEPS];
  sqrt_st_t sq_n_nxt [SQRT_STEPS];
  sqrt_st_t sq_d_nxt [SQRT_STEPS];

  always_comb begin
    sqrt_st_t n0, d0;
    n0 = '{x: {c_s_r, 16'h0000}, rem: '0, root: '0};
    d0 = '{x: {c_sxz_r, 16'h0000}, rem: '0, root: '0};
    sq_n_nxt[0] = sqrt_step(n0);
    sq_d_nxt[0] = sqrt_step(d0);
    for (int k = 1; k < SQRT_STEPS; k++) begin
      sq_n_nxt[k] = sqrt_step(sq_n_r[k-1]);
      sq_d_nxt[k] = sqrt_step(sq_d_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_STEPS; k++) sq_v_r[k] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= c_v_r;
      for (int k = 1; k < SQRT_STEPS; k++) sq_v_r[k] <= sq_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side_r[0] <= c_side_r;
      for (int k = 1; k < SQRT_STEPS; k++) sq_side_r[k] <= sq_side_r[k-1];
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sq_n_r[k] <= sq_n_nxt[k];
        sq_d_r[k] <= sq_d_nxt[k];
      end
    end
  end

  // Stage E: denominator and the roll term d8 * gy.
  logic               e_v_r, e_zero_r;
  logic [47:0]        e_den_r;
  logic signed [40:0] e_dgy_r;
  sq_side_t           e_side_r;
  logic [23:0]        n8, d8;
  logic signed [24:0] d8s;

  assign n8  = sq_n_r[SQRT_STEPS-1].root;
  assign d8  = sq_d_r[SQRT_STEPS-1].root;
  assign d8s = sq_side_r[SQRT_STEPS-1].az_neg ? -$signed({1'b0, d8}) : $signed({1'b0, d8});

  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else if (adv) e_v_r <= sq_v_r[SQRT_STEPS-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_zero_r <= (n8 == '0);
      e_den_r  <= (n8 == '0) ? {24'h000000, SCALE_DIV} : n8 * SCALE_DIV;
      e_dgy_r  <= 41'(d8s) * 41'(sq_side_r[SQRT_STEPS-1].gy);
      e_side_r <= sq_side_r[SQRT_STEPS-1];
    end
  end

  // Stage F: signed numerators.
  logic               f_v_r;
  logic signed [40:0] f_tx_r, f_ty_r;
  logic [47:0]        f_den_r;
  logic [31:0]        f_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) f_v_r <= 1'b0;
    else if (adv) f_v_r <= e_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (e_zero_r) begin
        f_tx_r <= '0;
        f_ty_r <= 41'(e_side_r.gy);
      end else begin
        f_tx_r <= {e_side_r.gsum[32:0], 8'h00};
        f_ty_r <= e_dgy_r - {e_side_r.aygz[32-1], e_side_r.aygz, 8'h00};
      end
      f_den_r <= e_den_r;
      f_m_r   <= e_side_r.m;
    end
  end

  // Stage G: sign and magnitude.
  logic        g_v_r, g_nx_r, g_ny_r;
  logic [39:0] g_mx_r, g_my_r;
  logic [47:0] g_den_r;
  logic [31:0] g_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) g_v_r <= 1'b0;
    else if (adv) g_v_r <= f_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_nx_r  <= f_tx_r[40];
      g_ny_r  <= f_ty_r[40];
      g_mx_r  <= f_tx_r[40] ? 40'(-f_tx_r) : f_tx_r[39:0];
      g_my_r  <= f_ty_r[40] ? 40'(-f_ty_r) : f_ty_r[39:0];
      g_den_r <= f_den_r;
      g_m_r   <= f_m_r;
    end
  end

  // Stage H: 20x32 partial products of magnitude times gain product.
  logic        h_v_r, h_nx_r, h_ny_r;
  logic [51:0] h_xlo_r, h_xhi_r, h_ylo_r, h_yhi_r;
  logic [47:0] h_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) h_v_r <= 1'b0;
    else if (adv) h_v_r <= g_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_xlo_r <= g_mx_r[19:0] * g_m_r;
      h_xhi_r <= g_mx_r[39:20] * g_m_r;
      h_ylo_r <= g_my_r[19:0] * g_m_r;
      h_yhi_r <= g_my_r[39:20] * g_m_r;
      h_nx_r  <= g_nx_r;
      h_ny_r  <= g_ny_r;
      h_den_r <= g_den_r;
    end
  end

  // Stage I: full numerators with the rounding half-denominator.
  logic        i_v_r, i_nx_r, i_ny_r;
  logic [72:0] i_numx_r, i_numy_r;
  logic [47:0] i_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) i_v_r <= 1'b0;
    else if (adv) i_v_r <= h_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_numx_r <= {1'b0, h_xhi_r, 20'h00000} + 73'(h_xlo_r) + 73'(h_den_r[47:1]);
      i_numy_r <= {1'b0, h_yhi_r, 20'h00000} + 73'(h_ylo_r) + 73'(h_den_r[47:1]);
      i_nx_r   <= h_nx_r;
      i_ny_r   <= h_ny_r;
      i_den_r  <= h_den_r;
    end
  end

  // Stage J: overflow check and divider set-up.
  logic     j_v_r;
  div_st_t  j_x_r, j_y_r;
  dv_side_t j_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) j_v_r <= 1'b0;
    else if (adv) j_v_r <= i_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_x_r          <= '{nlo: i_numx_r[23:0], rem: i_numx_r[71:24], q: '0};
      j_y_r          <= '{nlo: i_numy_r[23:0], rem: i_numy_r[71:24], q: '0};
      j_side_r.den   <= i_den_r;
      j_side_r.neg_x <= i_nx_r;
      j_side_r.neg_y <= i_ny_r;
      j_side_r.big_x <= (i_numx_r >= {1'b0, i_den_r, 24'h000000});
      j_side_r.big_y <= (i_numy_r >= {1'b0, i_den_r, 24'h000000});
    end
  end

  // Divider stages, one quotient bit each.
  logic     dv_v_r   [DIV_STEPS];
  div_st_t  dv_x_r   [DIV_STEPS];
  div_st_t  dv_y_r   [DIV_STEPS];
  dv_side_t dv_side_r[DIV_STEPS];
  div_st_t  dv_x_nxt [DIV_STEPS];
  div_st_t  dv_y_nxt [DIV_STEPS];

  always_comb begin
    dv_x_nxt[0] = div_step(j_x_r, j_side_r.den);
    dv_y_nxt[0] = div_step(j_y_r, j_side_r.den);
    for (int k = 1; k < DIV_STEPS; k++) begin
      dv_x_nxt[k] = div_step(dv_x_r[k-1], dv_side_r[k-1].den);
      dv_y_nxt[k] = div_step(dv_y_r[k-1], dv_side_r[k-1].den);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STEPS; k++) dv_v_r[k] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= j_v_r;
      for (int k = 1; k < DIV_STEPS; k++) dv_v_r[k] <= dv_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side_r[0] <= j_side_r;
      for (int k = 1; k < DIV_STEPS; k++) dv_side_r[k] <= dv_side_r[k-1];
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_x_r[k] <= dv_x_nxt[k];
        dv_y_r[k] <= dv_y_nxt[k];
      end
    end
  end

  // Output register: sign and saturation.
  function automatic logic [24:0] sat_move(logic [23:0] q, logic neg, logic big);
    logic [23:0] v;
    logic        s;
    s = 1'b0;
    if (neg) begin
      if (big || q > NEG_MIN_Q) begin
        s = 1'b1;
        v = NEG_MIN_Q;
      end else begin
        v = 24'(-q);
      end
    end else begin
      if (big || q > POS_MAX_Q) begin
        s = 1'b1;
        v = POS_MAX_Q;
      end else begin
        v = q;
      end
    end
    return {s, v};
  endfunction

  logic        [24:0] res_x, res_y;
  logic signed [23:0] out_mx_r, out_my_r;
  logic               out_sat_r;

  assign res_x = sat_move(dv_x_r[DIV_STEPS-1].q, dv_side_r[DIV_STEPS-1].neg_x,
                          dv_side_r[DIV_STEPS-1].big_x);
  assign res_y = sat_move(dv_y_r[DIV_STEPS-1].q, dv_side_r[DIV_STEPS-1].neg_y,
                          dv_side_r[DIV_STEPS-1].big_y);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= dv_v_r[DIV_STEPS-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mx_r  <= res_x[23:0];
      out_my_r  <= res_y[23:0];
      out_sat_r <= res_x[24] | res_y[24];
    end
  end

  assign out_beat.valid     = out_valid_r;
  assign out_beat.move_x    = out_mx_r;
  assign out_beat.move_y    = out_my_r;
  assign out_beat.saturated = out_sat_r;

endmodule

>>> rtl/imu_tcm_checker.sv
// Port-level checker for the tilt-compensated cursor motion block, with its bind.
// Depends on the top level imu_tilt_compensated_cursor_motion.
module imu_tcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_move_x,
  input logic [23:0] out_move_y,
  input logic        out_saturated
);

  // The output register is empty after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // An empty output stage never holds back the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A stalled result stalls the input.
  a_stall_prop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while output stalled");

  // A saturated result carries a clipped move.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_move_x == 24'h7FFFFF || out_move_x == 24'h800000 ||
       out_move_y == 24'h7FFFFF || out_move_y == 24'h800000))
    else $error("saturated flag without clipped move");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_move_x) &&
                                   $stable(out_move_y) && $stable(out_saturated)))
    else $error("output changed while stalled");

endmodule

bind imu_tilt_compensated_cursor_motion imu_tcm_checker u_imu_tcm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_beat.ready),
  .out_valid     (out_beat.valid),
  .out_ready     (out_beat.ready),
  .out_move_x    (out_beat.move_x),
  .out_move_y    (out_beat.move_y),
  .out_saturated (out_beat.saturated)
);
